// ===== hdl/bertlv_pkg.sv =====
// Shared types and constants for the BER TLV integer decoder.
// No dependencies; used by bertlv_core and ber_tlv_integer_decoder.
package bertlv_pkg;

    // Configuration register indexes
    localparam logic REG_EXPECTED_TAG = 1'b0;
    localparam logic REG_VALUE_MODE   = 1'b1;

    localparam logic [7:0] EXPECTED_TAG_RESET = 8'h02;
    localparam logic       VALUE_MODE_RESET   = 1'b0;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SMALL = 3'd1,
        ST_TAG   = 3'd2,
        ST_LONG  = 3'd3,
        ST_WIDE  = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] buffer_length;
        logic        first_byte;
        logic [7:0]  tlv_byte;
    } step_in_t;

    typedef struct packed {
        logic       value_mode;
        logic [7:0] expected_tag;
    } cfg_t;

    typedef struct packed {
        logic [15:0] total_bytes;
        logic [2:0]  header_bytes;
        logic [63:0] value_bits;
        status_t     status;
    } result_t;

endpackage

// ===== hdl/bertlv_core.sv =====
// Decoder state registers and the per-byte next-state / result logic.
// Depends on bertlv_pkg.
module bertlv_core #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  bertlv_pkg::step_in_t step_in,
    input  bertlv_pkg::cfg_t    cfg,
    output logic                res_valid,
    output bertlv_pkg::result_t res
);

    localparam int CLW = 8 * MAX_LENGTH_BYTES;
    localparam int TW  = (CLW + 1 > 17) ? CLW + 1 : 17;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_FIRST,
        PH_LEN_MORE,
        PH_CONTENT
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [2:0]       len_left_reg, len_left_next;
    logic [CLW-1:0]   content_len_reg, content_len_next;
    logic [15:0]      content_left_reg, content_left_next;
    logic [63:0]      acc_reg, acc_next;
    logic [2:0]       hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]      avail_reg, avail_next;

    logic             hdr_done;
    logic [TW-1:0]    hdr_total;
    logic [TW-1:0]    end_total;
    logic [6:0]       len_count;
    logic [31:0]      sval;
    logic [63:0]      final_value;

    // Sign extension by content length in signed mode
    always_comb begin
        sval = acc_next[31:0];
        if (content_len_reg == CLW'(1)) begin
            sval = {{24{acc_next[7]}}, acc_next[7:0]};
        end else if (content_len_reg == CLW'(2)) begin
            sval = {{16{acc_next[15]}}, acc_next[15:0]};
        end else if (content_len_reg == CLW'(3)) begin
            sval = {{8{acc_next[23]}}, acc_next[23:0]};
        end
        final_value = cfg.value_mode ? acc_next : {{32{sval[31]}}, sval};
    end

    assign len_count = step_in.tlv_byte[6:0];
    assign hdr_total = TW'(content_len_next) + TW'(hdr_cnt_next);
    assign end_total = TW'(content_len_reg) + TW'(hdr_cnt_reg);

    always_comb begin
        phase_next        = phase_reg;
        len_left_next     = len_left_reg;
        content_len_next  = content_len_reg;
        content_left_next = content_left_reg;
        acc_next          = acc_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        avail_next        = avail_reg;
        hdr_done          = 1'b0;
        res_valid         = 1'b0;
        res.status        = bertlv_pkg::ST_OK;
        res.value_bits    = 64'd0;
        res.header_bytes  = 3'd0;
        res.total_bytes   = 16'd0;

        if (step_in.first_byte) begin
            avail_next        = step_in.buffer_length;
            content_len_next  = '0;
            content_left_next = 16'd0;
            acc_next          = 64'd0;
            len_left_next     = 3'd0;
            hdr_cnt_next      = 3'd0;
            if (step_in.buffer_length < 16'd2) begin
                res_valid  = 1'b1;
                res.status = bertlv_pkg::ST_SMALL;
                phase_next = PH_IDLE;
            end else if (step_in.tlv_byte != cfg.expected_tag) begin
                res_valid  = 1'b1;
                res.status = bertlv_pkg::ST_TAG;
                phase_next = PH_IDLE;
            end else begin
                hdr_cnt_next = 3'd1;
                phase_next   = PH_LEN_FIRST;
            end
        end else begin
            case (phase_reg)
                PH_LEN_FIRST: begin
                    hdr_cnt_next = 3'd2;
                    if (!step_in.tlv_byte[7]) begin
                        content_len_next = CLW'(step_in.tlv_byte[6:0]);
                        hdr_done         = 1'b1;
                    end else if (len_count > 7'(MAX_LENGTH_BYTES)) begin
                        res_valid  = 1'b1;
                        res.status = bertlv_pkg::ST_WIDE;
                        phase_next = PH_IDLE;
                    end else begin
                        content_len_next = '0;
                        if (len_count == 7'd0) begin
                            hdr_done = 1'b1;
                        end else begin
                            len_left_next = len_count[2:0];
                            phase_next    = PH_LEN_MORE;
                        end
                    end
                end
                PH_LEN_MORE: begin
                    content_len_next = CLW'({content_len_reg, step_in.tlv_byte});
                    hdr_cnt_next     = hdr_cnt_reg + 3'd1;
                    len_left_next    = len_left_reg - 3'd1;
                    if (len_left_next == 3'd0) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_CONTENT: begin
                    acc_next          = {acc_reg[55:0], step_in.tlv_byte};
                    content_left_next = content_left_reg - 16'd1;
                    if (content_left_next == 16'd0) begin
                        res_valid        = 1'b1;
                        res.status       = bertlv_pkg::ST_OK;
                        res.value_bits   = final_value;
                        res.header_bytes = hdr_cnt_reg;
                        res.total_bytes  = end_total[15:0];
                        phase_next       = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase

            // Header complete: fit check, then empty or content phase
            if (hdr_done) begin
                if (hdr_total > TW'(avail_reg)) begin
                    res_valid  = 1'b1;
                    res.status = bertlv_pkg::ST_LONG;
                    phase_next = PH_IDLE;
                end else if (content_len_next == '0) begin
                    res_valid        = 1'b1;
                    res.status       = bertlv_pkg::ST_OK;
                    res.header_bytes = hdr_cnt_next;
                    res.total_bytes  = 16'(hdr_cnt_next);
                    phase_next       = PH_IDLE;
                end else begin
                    content_left_next = 16'(content_len_next);
                    acc_next          = 64'd0;
                    phase_next        = PH_CONTENT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            len_left_reg     <= 3'd0;
            content_len_reg  <= '0;
            content_left_reg <= 16'd0;
            acc_reg          <= 64'd0;
            hdr_cnt_reg      <= 3'd0;
            avail_reg        <= 16'd0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            len_left_reg     <= len_left_next;
            content_len_reg  <= content_len_next;
            content_left_reg <= content_left_next;
            acc_reg          <= acc_next;
            hdr_cnt_reg      <= hdr_cnt_next;
            avail_reg        <= avail_next;
        end
    end

endmodule

// ===== hdl/ber_tlv_integer_decoder.sv =====
// A byte accepted into the input register is decoded when the pipeline advances;
// its result (if any) is registered and shown on m_*. Throughput: one byte per
// cycle unless m_tready holds back a result; set by bertlv_core's single pass.
// Reset (aresetn low, synchronous): both registers empty, decoder idle, expected
// tag 0x02, signed mode. Top level: input/result registers and config registers.
// Depends on bertlv_pkg and bertlv_core.
module ber_tlv_integer_decoder #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] tlv_byte, [23:8] buffer_length
    input  logic        s_tuser,   // [0] first_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // [2:0] status, [66:3] value_bits,
                                   // [69:67] header_bytes, [85:70] total_bytes,
                                   // [87:86] zero
);

    logic                 in_valid_reg;
    bertlv_pkg::step_in_t in_data_reg;
    logic                 out_valid_reg;
    bertlv_pkg::result_t  out_data_reg;
    bertlv_pkg::cfg_t     cfg_reg;

    logic                 advance;
    logic                 step_en;
    logic                 res_valid;
    bertlv_pkg::result_t  res;

    // Pipeline moves when the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg.tlv_byte      <= s_tdata[7:0];
            in_data_reg.buffer_length <= s_tdata[23:8];
            in_data_reg.first_byte    <= s_tuser;
        end
    end

    // Config regs: user must write only while decoder is quiet; not enforced here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_tag <= bertlv_pkg::EXPECTED_TAG_RESET;
            cfg_reg.value_mode   <= bertlv_pkg::VALUE_MODE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bertlv_pkg::REG_EXPECTED_TAG: cfg_reg.expected_tag <= cfg_wdata;
                bertlv_pkg::REG_VALUE_MODE:   cfg_reg.value_mode   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    bertlv_core #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .step_in   (in_data_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: loaded with whatever the step produced (or empty)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_en && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg.total_bytes, out_data_reg.header_bytes,
                       out_data_reg.value_bits, out_data_reg.status};

endmodule
